// ===== design/tmub_pkg.sv =====
package tmub_pkg;

  localparam int WIDTH  = 64;
  localparam int PORT_W = 64;
  localparam int CHUNK  = 8;
  localparam int NCHUNK = (WIDTH + CHUNK - 1) / CHUNK;
  localparam int PC_W   = $clog2(CHUNK + 1);
  localparam int CNT_W  = $clog2(WIDTH + 1);

  // Select module popcount and output registers plus the trit stage chain
  localparam int LATENCY = WIDTH + 2;

  typedef struct packed {
    logic [WIDTH-1:0] v;
    logic [WIDTH-1:0] m;
  } tnum_t;

  typedef struct packed {
    logic valid;
    logic bidir;
  } ctl_t;

  // One long-multiplication step: accumulator, shifted multiplicand,
  // remaining multiplier trits (bit 0 is the current trit).
  typedef struct packed {
    ctl_t  ctl;
    tnum_t acc;
    tnum_t sh;
    tnum_t x;
  } st_t;

  function automatic tnum_t tw_add(tnum_t a, tnum_t b);
    logic [WIDTH-1:0] sm;
    logic [WIDTH-1:0] sv;
    logic [WIDTH-1:0] sig;
    logic [WIDTH-1:0] unk;
    tnum_t            r;
    sm  = a.m + b.m;
    sv  = a.v + b.v;
    sig = sm + sv;
    unk = (sig ^ sv) | a.m | b.m;
    r.v = sv & ~unk;
    r.m = unk;
    return r;
  endfunction

  function automatic tnum_t tw_union(tnum_t a, tnum_t b);
    logic [WIDTH-1:0] unk;
    tnum_t            r;
    unk = (a.v ^ b.v) | a.m | b.m;
    r.v = a.v & b.v & ~unk;
    r.m = unk;
    return r;
  endfunction

endpackage

// ===== design/tmub_stage.sv =====
module tmub_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  tmub_pkg::st_t st_i,
  output tmub_pkg::st_t st_o
);
  import tmub_pkg::*;

  tnum_t add_w;
  tnum_t uni_w;
  st_t   st_nxt;
  ctl_t  ctl_r;
  tnum_t acc_r;
  tnum_t sh_r;
  tnum_t x_r;

  always_comb begin
    add_w = tw_add(st_i.acc, st_i.sh);
    uni_w = tw_union(st_i.acc, add_w);
    st_nxt = st_i;
    // value bit wins over mask bit: malformed trit is a certain 1
    if (st_i.x.v[0]) begin
      st_nxt.acc = add_w;
    end else if (st_i.x.m[0]) begin
      st_nxt.acc = uni_w;
    end
    st_nxt.sh.v = st_i.sh.v << 1;
    st_nxt.sh.m = st_i.sh.m << 1;
    st_nxt.x.v  = st_i.x.v >> 1;
    st_nxt.x.m  = st_i.x.m >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= st_nxt.ctl;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= st_nxt.acc;
    sh_r  <= st_nxt.sh;
    x_r   <= st_nxt.x;
  end

  assign st_o = '{ctl: ctl_r, acc: acc_r, sh: sh_r, x: x_r};

endmodule

// ===== design/tmub_mul.sv =====
module tmub_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  tmub_pkg::ctl_t ctl_i,
  input  tmub_pkg::tnum_t x_i,
  input  tmub_pkg::tnum_t y_i,
  output tmub_pkg::st_t  st_o
);
  import tmub_pkg::*;

  st_t chain [0:WIDTH];

  assign chain[0] = '{ctl: ctl_i, acc: '0, sh: y_i, x: x_i};

  for (genvar i = 0; i < WIDTH; i++) begin : g_trit
    tmub_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .st_i  (chain[i]),
      .st_o  (chain[i+1])
    );
  end

  assign st_o = chain[WIDTH];

endmodule

// ===== design/tmub_select.sv =====
module tmub_select (
  input  logic             clk,
  input  logic             rst_n,
  input  tmub_pkg::ctl_t   ctl_i,
  input  tmub_pkg::tnum_t  ab_i,
  input  tmub_pkg::tnum_t  ba_i,
  output logic             valid_o,
  output tmub_pkg::tnum_t  res_o,
  output logic             order_o
);
  import tmub_pkg::*;

  localparam int PAD_W = NCHUNK * CHUNK;

  // stage 1: per-chunk popcounts
  logic [PAD_W-1:0]  ab_pad;
  logic [PAD_W-1:0]  ba_pad;
  logic [PC_W-1:0]   ab_pc_nxt [NCHUNK];
  logic [PC_W-1:0]   ba_pc_nxt [NCHUNK];
  logic [PC_W-1:0]   ab_pc_r   [NCHUNK];
  logic [PC_W-1:0]   ba_pc_r   [NCHUNK];
  ctl_t              ctl_r;
  tnum_t             ab_r;
  tnum_t             ba_r;

  // stage 2: totals, compare, output register
  logic [CNT_W-1:0]  ab_cnt;
  logic [CNT_W-1:0]  ba_cnt;
  logic              take_ba;
  logic              valid_r;
  tnum_t             res_r;
  logic              order_r;

  assign ab_pad = PAD_W'(ab_i.m);
  assign ba_pad = PAD_W'(ba_i.m);

  always_comb begin
    for (int c = 0; c < NCHUNK; c++) begin
      ab_pc_nxt[c] = '0;
      ba_pc_nxt[c] = '0;
      for (int b = 0; b < CHUNK; b++) begin
        ab_pc_nxt[c] = ab_pc_nxt[c] + PC_W'(ab_pad[c*CHUNK+b]);
        ba_pc_nxt[c] = ba_pc_nxt[c] + PC_W'(ba_pad[c*CHUNK+b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    ab_r    <= ab_i;
    ba_r    <= ba_i;
    ab_pc_r <= ab_pc_nxt;
    ba_pc_r <= ba_pc_nxt;
  end

  always_comb begin
    ab_cnt = '0;
    ba_cnt = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      ab_cnt = ab_cnt + CNT_W'(ab_pc_r[c]);
      ba_cnt = ba_cnt + CNT_W'(ba_pc_r[c]);
    end
    // tie goes to the swapped order
    take_ba = ctl_r.bidir && !(ab_cnt < ba_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= take_ba ? ba_r : ab_r;
    order_r <= take_ba;
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;
  assign order_o = order_r;

endmodule

// ===== design/tnum_multiply_union_bidir.sv =====
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+-------------------------------
// input    | in_a_value in_a_mask in_b_value in_b_mask     | start & !busy (busy stays low)
// result   | out_res_value out_res_mask out_chosen_order   | out_valid, one-cycle strobe
// config   | cfg_data (bidir_enable)                       | cfg_valid & cfg_ready
//
// Fully pipelined: one transaction per cycle; the result is strobed after one register per
// trit of the multiplier, then the popcount and select registers.
// Each trit stage does one tristate add plus union.
// Sync active-low reset clears all valid bits and sets bidir_enable to 1.
// The receiver cannot stall, so busy is tied low and nothing ever backs up.
// bidir_enable is sampled at start and rides along with the transaction.
module tnum_multiply_union_bidir (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tmub_pkg::PORT_W-1:0] in_a_value,
  input  logic [tmub_pkg::PORT_W-1:0] in_a_mask,
  input  logic [tmub_pkg::PORT_W-1:0] in_b_value,
  input  logic [tmub_pkg::PORT_W-1:0] in_b_mask,
  output logic                        out_valid,
  output logic [tmub_pkg::PORT_W-1:0] out_res_value,
  output logic [tmub_pkg::PORT_W-1:0] out_res_mask,
  output logic                        out_chosen_order,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data
);
  import tmub_pkg::*;

  logic  bidir_r;
  ctl_t  in_ctl;
  tnum_t a_w;
  tnum_t b_w;
  st_t   ab_st;
  st_t   ba_st;
  tnum_t res_w;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bidir_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      bidir_r <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // inputs cut to WIDTH bits
  assign a_w.v = in_a_value[WIDTH-1:0];
  assign a_w.m = in_a_mask[WIDTH-1:0];
  assign b_w.v = in_b_value[WIDTH-1:0];
  assign b_w.m = in_b_mask[WIDTH-1:0];

  assign in_ctl.valid = start && !busy;
  assign in_ctl.bidir = bidir_r;

  // a times b: walks the trits of a
  tmub_mul u_mul_ab (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (in_ctl),
    .x_i   (a_w),
    .y_i   (b_w),
    .st_o  (ab_st)
  );

  // b times a: always computed, used only when bidir was set
  tmub_mul u_mul_ba (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (in_ctl),
    .x_i   (b_w),
    .y_i   (a_w),
    .st_o  (ba_st)
  );

  tmub_select u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ab_st.ctl),
    .ab_i    (ab_st.acc),
    .ba_i    (ba_st.acc),
    .valid_o (out_valid),
    .res_o   (res_w),
    .order_o (out_chosen_order)
  );

  // upper port bits are zero for narrow widths
  assign out_res_value = PORT_W'(res_w.v);
  assign out_res_mask  = PORT_W'(res_w.m);

  // both chains carry the same transactions in lockstep
  a_chain_sync: assert property (@(posedge clk) disable iff (!rst_n)
    ab_st.ctl == ba_st.ctl)
    else $error("multiplier chains out of step");

  // every multiplier trit has been consumed at the end of the chain
  a_trits_done: assert property (@(posedge clk) disable iff (!rst_n)
    ab_st.ctl.valid |-> (ab_st.x.v == '0 && ab_st.x.m == '0 &&
                         ba_st.x.v == '0 && ba_st.x.m == '0))
    else $error("multiplier trits left over at chain end");

  // the swapped order can only win when bidir was on for that transaction
  a_order_bidir: assert property (@(posedge clk) disable iff (!rst_n)
    (ab_st.ctl.valid && !ab_st.ctl.bidir) |=> ##1 (out_valid && !out_chosen_order))
    else $error("swapped order chosen with bidir off");

endmodule

// ===== sim/tmub_product_check.sv =====
`timescale 1ns / 100ps

module tmub_product_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [tmub_pkg::PORT_W-1:0] in_a_value,
  input  logic [tmub_pkg::PORT_W-1:0] in_a_mask,
  input  logic [tmub_pkg::PORT_W-1:0] in_b_value,
  input  logic [tmub_pkg::PORT_W-1:0] in_b_mask,
  input  logic                        out_valid,
  input  logic [tmub_pkg::PORT_W-1:0] out_res_value,
  input  logic [tmub_pkg::PORT_W-1:0] out_res_mask,
  input  logic                        out_chosen_order,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_data,
  output int                          error_count,
  output int                          outstanding,
  output int                          product_count
);
  import tmub_pkg::*;

  typedef struct packed {
    logic [PORT_W-1:0] value;
    logic [PORT_W-1:0] mask;
    logic              swapped;
  } product_t;

  product_t expected_products[$];
  product_t oldest;
  logic     bidir_mode;
  int       fail_count = 0;
  int       checked    = 0;
  int       queued     = 0;

  assign error_count   = fail_count;
  assign outstanding   = queued;
  assign product_count = checked;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
    fail_count++;
  endtask

  // Tristate add: carries that differ between the all-min and all-max sums are unknown.
  function automatic tnum_t tri_sum(tnum_t x, tnum_t y);
    logic [WIDTH-1:0] val_sum;
    logic [WIDTH-1:0] unk_sum;
    logic [WIDTH-1:0] unknown;
    tnum_t            r;
    val_sum = x.v + y.v;
    unk_sum = x.m + y.m;
    unknown = ((val_sum + unk_sum) ^ val_sum) | x.m | y.m;
    r.v = val_sum & ~unknown;
    r.m = unknown;
    return r;
  endfunction

  function automatic tnum_t tri_join(tnum_t x, tnum_t y);
    logic [WIDTH-1:0] unknown;
    tnum_t            r;
    unknown = (x.v ^ y.v) | x.m | y.m;
    r.v = x.v & y.v & ~unknown;
    r.m = unknown;
    return r;
  endfunction

  // Long multiplication over the trits of x; a set value bit wins over the mask bit.
  function automatic tnum_t tri_product(tnum_t x, tnum_t y);
    tnum_t acc;
    tnum_t addend;
    acc    = '0;
    addend = y;
    for (int i = 0; i < WIDTH; i++) begin
      if (x.v[i]) begin
        acc = tri_sum(acc, addend);
      end else if (x.m[i]) begin
        acc = tri_join(acc, tri_sum(acc, addend));
      end
      addend.v = addend.v << 1;
      addend.m = addend.m << 1;
    end
    return acc;
  endfunction

  function automatic int unknown_bits(logic [WIDTH-1:0] w);
    int n;
    n = 0;
    for (int i = 0; i < WIDTH; i++) begin
      n += int'(w[i]);
    end
    return n;
  endfunction

  function automatic product_t predict_product(logic [PORT_W-1:0] av, logic [PORT_W-1:0] am,
                                               logic [PORT_W-1:0] bv, logic [PORT_W-1:0] bm,
                                               logic both_orders);
    tnum_t    a;
    tnum_t    b;
    tnum_t    fwd;
    tnum_t    rev;
    product_t p;
    a.v = av[WIDTH-1:0];
    a.m = am[WIDTH-1:0];
    b.v = bv[WIDTH-1:0];
    b.m = bm[WIDTH-1:0];
    fwd = tri_product(a, b);
    p   = '0;
    p.value[WIDTH-1:0] = fwd.v;
    p.mask[WIDTH-1:0]  = fwd.m;
    if (both_orders) begin
      rev = tri_product(b, a);
      // swapped order takes ties
      if (!(unknown_bits(fwd.m) < unknown_bits(rev.m))) begin
        p.value[WIDTH-1:0] = rev.v;
        p.mask[WIDTH-1:0]  = rev.m;
        p.swapped          = 1'b1;
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_products.delete();
      bidir_mode <= 1'b1;
      queued     <= 0;
    end else begin
      if (out_valid) begin
        if (expected_products.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_res_value, '0);
        end else begin
          oldest = expected_products.pop_front();
          if (out_res_value !== oldest.value)
            report_mismatch("res_value", out_res_value, oldest.value);
          if (out_res_mask !== oldest.mask)
            report_mismatch("res_mask", out_res_mask, oldest.mask);
          if (out_chosen_order !== oldest.swapped)
            report_mismatch("chosen_order", 64'(out_chosen_order), 64'(oldest.swapped));
          checked++;
        end
      end
      if (start && !busy) begin
        expected_products.push_back(predict_product(in_a_value, in_a_mask,
                                                    in_b_value, in_b_mask, bidir_mode));
      end
      if (cfg_valid && cfg_ready) begin
        bidir_mode <= cfg_data;
      end
      queued <= expected_products.size();
    end
  end

endmodule

// ===== sim/tnum_multiply_union_bidir_tb.sv =====
`timescale 1ns / 100ps

module tnum_multiply_union_bidir_tb;
  import tmub_pkg::*;

  localparam int RANDOM_PER_PHASE = 225;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              start      = 1'b0;
  logic              cfg_valid  = 1'b0;
  logic              cfg_data   = 1'b0;
  logic [PORT_W-1:0] in_a_value = '0;
  logic [PORT_W-1:0] in_a_mask  = '0;
  logic [PORT_W-1:0] in_b_value = '0;
  logic [PORT_W-1:0] in_b_mask  = '0;

  logic              busy;
  logic              cfg_ready;
  logic              out_valid;
  logic [PORT_W-1:0] out_res_value;
  logic [PORT_W-1:0] out_res_mask;
  logic              out_chosen_order;

  int error_count;
  int outstanding;
  int product_count;
  int sent_count = 0;
  int cfg_writes = 0;
  bit no_gaps    = 1'b0;

  // Bidir settings walked after the directed part (reset value is 1).
  logic phase_bidir [4] = '{1'b0, 1'b1, 1'b0, 1'b1};

  tnum_multiply_union_bidir dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_a_value       (in_a_value),
    .in_a_mask        (in_a_mask),
    .in_b_value       (in_b_value),
    .in_b_mask        (in_b_mask),
    .out_valid        (out_valid),
    .out_res_value    (out_res_value),
    .out_res_mask     (out_res_mask),
    .out_chosen_order (out_chosen_order),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // Watches all three channels, predicts each product and compares.
  tmub_product_check product_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_a_value       (in_a_value),
    .in_a_mask        (in_a_mask),
    .in_b_value       (in_b_value),
    .in_b_mask        (in_b_mask),
    .out_valid        (out_valid),
    .out_res_value    (out_res_value),
    .out_res_mask     (out_res_mask),
    .out_chosen_order (out_chosen_order),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .error_count      (error_count),
    .outstanding      (outstanding),
    .product_count    (product_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far above a run with every gap at its longest.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random tnum: mask density varies from none to full; about 1 in 10 keeps
  // value/mask overlap (malformed trits read as certain 1).
  task automatic gen_tnum(output logic [63:0] v, output logic [63:0] m);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       m = '0;
      1:       m = '1;
      2, 3:    m = rand_word() & rand_word() & rand_word();
      4:       m = rand_word() | rand_word();
      5:       m = 64'd1 << $urandom_range(0, 63);
      default: m = rand_word();
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0:       v = '0;
      1:       v = 64'($urandom_range(0, 255));
      2:       v = '1;
      default: v = rand_word();
    endcase
    if ($urandom_range(0, 9) != 0) v = v & ~m;
  endtask

  // Leaves start high on return so the next transaction can follow with no gap.
  task automatic send_pair(input logic [63:0] av, input logic [63:0] am,
                           input logic [63:0] bv, input logic [63:0] bm);
    start      <= 1'b1;
    in_a_value <= av;
    in_a_mask  <= am;
    in_b_value <= bv;
    in_b_mask  <= bm;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  task automatic idle_between();
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops start and lets the checker's count reflect the last accepted transaction before polling.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_bidir(input logic val);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    logic [63:0] av;
    logic [63:0] am;
    logic [63:0] bv;
    logic [63:0] bm;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, bidir at its reset value of 1.
    send_pair('0, '0, '0, '0);
    send_pair('1, '0, '1, '0);                       // known max * known max
    idle_between();
    send_pair('0, '1, 64'd3, '0);                    // fully unknown a
    send_pair(64'd5, '0, '0, '1);                    // fully unknown b
    send_pair('0, '1, '0, '1);                       // both fully unknown
    idle_between();
    send_pair(64'd1, '0, 64'h9e37_79b9_7f4a_7c15, '0);
    send_pair(64'h8000_0000_0000_0000, '0, 64'h8000_0000_0000_0000, '0);
    send_pair('1, '1, 64'd7, '0);                    // every trit malformed
    idle_between();
    send_pair(64'hf0f0_f0f0_f0f0_f0f0, 64'hff00_ff00_ff00_ff00,
              64'h0000_0000_0000_0100, 64'h0000_0000_0001_0000);
    send_pair('0, 64'd1, '1, '0);                    // lone unknown lsb
    send_pair(64'h0000_0000_0000_1204, 64'h0000_0000_0000_0030,
              64'h0000_0000_0000_1204, 64'h0000_0000_0000_0030); // symmetric: tie
    send_pair('0, '0, '0, '1);                       // known zero * unknown
    idle_between();
    send_pair('0, 64'h8000_0000_0000_0000, 64'd1, '0); // unknown msb
    send_pair(64'd2, '0, 64'd1, 64'd2);
    send_pair(64'h0000_0000_0000_00ff, 64'h0000_0000_0000_ff00, 64'd3, '0);
    drain();

    // Random part, one phase per entry of phase_bidir.
    foreach (phase_bidir[p]) begin
      write_bidir(phase_bidir[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        idle_between();
        gen_tnum(av, am);
        gen_tnum(bv, bm);
        send_pair(av, am, bv, bm);
      end
      drain();
    end

    // Catch any stray result after the pipeline has emptied.
    repeat (LATENCY + 8) @(posedge clk);

    $display("Run: %0d transactions sent, %0d products compared, %0d bidir writes",
             sent_count, product_count, cfg_writes);
    $display("Covered both bidir settings, malformed trits, full/empty masks, %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tmub_pkg.sv
design/tmub_stage.sv
design/tmub_mul.sv
design/tmub_select.sv
design/tnum_multiply_union_bidir.sv
sim/tmub_product_check.sv
sim/tnum_multiply_union_bidir_tb.sv
